>>> rtl/round_robin_reg_allocator_unit_macros.svh
// Assertion macros for the round-robin register allocator checker.
// Included by the checker file only; no other dependencies.
`ifndef ROUND_ROBIN_REG_ALLOCATOR_UNIT_MACROS_SVH
`define ROUND_ROBIN_REG_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, off during reset
`define RRRA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rrra check failed");

// Next-cycle implication, off during reset
`define RRRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rrra check failed");

`endif

>>> rtl/rrra_pkg.sv
// Shared constants, codes and controller/datapath types for the allocator.
// No dependencies.
package rrra_pkg;

  localparam int REG_W     = 5;
  localparam int MASK_W    = 32;
  localparam int NUM_REGS  = 32;
  // compare width wide enough for NUM_REGS up to 64
  localparam int REG_CMP_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam int SCAN_CNT  = 32;
  localparam int SCAN_W    = $clog2(SCAN_CNT);

  // reset values of the configuration registers
  localparam logic [REG_W-1:0] FIRST_RST    = REG_W'(1);
  localparam logic [REG_W-1:0] LAST_RST     = REG_W'(31);
  localparam logic [REG_W-1:0] RESTART_RST  = REG_W'(8);
  localparam logic [REG_W-1:0] RESERVED_RST = REG_W'(15);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_REG    = 2'd0,
    CFG_LAST_REG     = 2'd1,
    CFG_RESTART_REG  = 2'd2,
    CFG_RESERVED_REG = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    OP_RESTART = 1'b0,
    OP_ALLOC   = 1'b1
  } opcode_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture request beat, seed scan
    logic step;    // advance to next candidate
    logic commit;  // write result register, update pointer
  } rrra_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic finish;     // result known this cycle
    logic slot_free;  // output register can take a beat
  } rrra_stat_t;

endpackage

>>> rtl/rrra_if.sv
// Request and response channel interfaces for the allocator.
// Depends on rrra_pkg.
interface rrra_req_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [rrra_pkg::MASK_W-1:0]   busy_mask;

  modport source (output valid, output opcode, output busy_mask, input ready);
  modport sink   (input valid, input opcode, input busy_mask, output ready);
endinterface

interface rrra_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rrra_pkg::REG_W-1:0]    chosen_reg;
  logic                          alloc_failed;

  modport source (output valid, output chosen_reg, output alloc_failed, input ready);
  modport sink   (input valid, input chosen_reg, input alloc_failed, output ready);
endinterface

>>> rtl/rrra_ctrl.sv
// Allocator controller: accepts a request beat, steps the scan, commits the result.
// Depends on rrra_pkg.
module rrra_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  rrra_pkg::rrra_stat_t stat,
  output rrra_pkg::rrra_cmd_t  cmd
);

  rrra_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrra_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    case (state)
      rrra_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = rrra_pkg::ST_SCAN;
        end
      end
      rrra_pkg::ST_SCAN: begin
        if (stat.finish) begin
          // hold until the output register has room
          if (stat.slot_free) begin
            cmd.commit = 1'b1;
            state_next = rrra_pkg::ST_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_next = rrra_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/rrra_dp.sv
// Allocator datapath: config registers, search pointer, candidate walk, result register.
// Depends on rrra_pkg.
module rrra_dp (
  input  logic                           clk,
  input  logic                           rst,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [rrra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rrra_pkg::REG_W-1:0]     cfg_data,
  // request payload
  input  logic                           req_opcode,
  input  logic [rrra_pkg::MASK_W-1:0]    req_busy_mask,
  // response side
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic [rrra_pkg::REG_W-1:0]     rsp_chosen_reg,
  output logic                           rsp_alloc_failed,
  // controller link
  input  rrra_pkg::rrra_cmd_t            cmd,
  output rrra_pkg::rrra_stat_t           stat
);

  logic [rrra_pkg::REG_W-1:0]  first_reg, last_reg, restart_reg, reserved_reg;
  logic [rrra_pkg::REG_W-1:0]  search_pointer, search_pointer_next;
  logic                        op;
  logic [rrra_pkg::MASK_W-1:0] mask;
  logic [rrra_pkg::REG_W-1:0]  start, cand;
  logic [rrra_pkg::SCAN_W-1:0] scan_cnt;

  logic                        cand_free, resv_free, wrapped, hit, last_try;
  logic [rrra_pkg::REG_W-1:0]  cand_succ, res_chosen;
  logic                        res_failed;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_reg    <= rrra_pkg::FIRST_RST;
      last_reg     <= rrra_pkg::LAST_RST;
      restart_reg  <= rrra_pkg::RESTART_RST;
      reserved_reg <= rrra_pkg::RESERVED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rrra_pkg::CFG_FIRST_REG:    first_reg    <= cfg_data;
        rrra_pkg::CFG_LAST_REG:     last_reg     <= cfg_data;
        rrra_pkg::CFG_RESTART_REG:  restart_reg  <= cfg_data;
        rrra_pkg::CFG_RESERVED_REG: reserved_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  // successor in the cyclic range
  assign cand_succ = (cand == last_reg) ? first_reg : cand + rrra_pkg::REG_W'(1);

  // candidate tests; indices past the register file count as busy
  assign cand_free = (rrra_pkg::REG_CMP_W'(cand) < rrra_pkg::REG_CMP_W'(rrra_pkg::NUM_REGS))
                     && !mask[cand];
  assign resv_free = (rrra_pkg::REG_CMP_W'(reserved_reg)
                      < rrra_pkg::REG_CMP_W'(rrra_pkg::NUM_REGS))
                     && !mask[reserved_reg];
  assign wrapped   = (scan_cnt != '0) && (cand == start);
  assign hit       = !wrapped && (cand != reserved_reg) && cand_free;
  assign last_try  = (scan_cnt == rrra_pkg::SCAN_W'(rrra_pkg::SCAN_CNT - 1));

  assign stat.finish    = (op == rrra_pkg::OP_RESTART) || hit || wrapped || last_try;
  assign stat.slot_free = !rsp_valid || rsp_ready;

  // result and pointer update
  always_comb begin
    res_chosen          = '0;
    res_failed          = 1'b0;
    search_pointer_next = search_pointer;
    if (op == rrra_pkg::OP_RESTART) begin
      search_pointer_next = restart_reg;
    end else if (hit) begin
      res_chosen          = cand;
      search_pointer_next = cand_succ;
    end else if (resv_free) begin
      res_chosen = reserved_reg;
    end else begin
      res_failed = 1'b1;
    end
  end

  // search pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      search_pointer <= rrra_pkg::FIRST_RST;
    end else if (cmd.commit) begin
      search_pointer <= search_pointer_next;
    end
  end

  // scan registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= req_opcode;
      mask     <= req_busy_mask;
      start    <= search_pointer;
      cand     <= search_pointer;
      scan_cnt <= '0;
    end else if (cmd.step) begin
      cand     <= cand_succ;
      scan_cnt <= scan_cnt + rrra_pkg::SCAN_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_chosen_reg   <= res_chosen;
      rsp_alloc_failed <= res_failed;
    end
  end

endmodule

>>> rtl/round_robin_reg_allocator_unit.sv
// Top level of the round-robin temporary register allocator.
// Depends on rrra_pkg, rrra_if, rrra_ctrl and rrra_dp.
//
//   channel  dir  payload                    handshake
//   req      in   opcode, busy_mask[31:0]    valid/ready
//   rsp      out  chosen_reg[4:0], failed    valid/ready
//   cfg      in   cfg_index[1:0], cfg_data   cfg_we, no wait
//
// A restart beat is loaded, finishes its scan at once and commits; an allocate beat
// walks at most 32 candidates until one is taken, the walk wraps or the scan count runs out.
// The walk checks one candidate per cycle in the datapath.
// Synchronous active-high reset; no clearing pass.
// req is ready again once the result sits in the output register, even if rsp
// is stalled; a finished scan waits while the output register is still full.
module round_robin_reg_allocator_unit (
  input  logic                           clk,
  input  logic                           rst,
  rrra_req_if.sink                       req,
  rrra_rsp_if.source                     rsp,
  input  logic                           cfg_we,
  input  logic [rrra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rrra_pkg::REG_W-1:0]     cfg_data
);

  rrra_pkg::rrra_cmd_t  cmd;
  rrra_pkg::rrra_stat_t stat;

  rrra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rrra_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .req_opcode       (req.opcode),
    .req_busy_mask    (req.busy_mask),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_chosen_reg   (rsp.chosen_reg),
    .rsp_alloc_failed (rsp.alloc_failed),
    .cmd              (cmd),
    .stat             (stat)
  );

endmodule

>>> rtl/rrra_checker.sv
// Port-level checks for the allocator, bound to the top level.
// Depends on rrra_pkg and round_robin_reg_allocator_unit_macros.svh.
`include "round_robin_reg_allocator_unit_macros.svh"

module rrra_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [rrra_pkg::REG_W-1:0] chosen_reg,
  input logic                       alloc_failed
);

  // one beat in flight: after an accept the request side closes
  `RRRA_ASSERT_NEXT(a_one_in_flight, clk, rst, req_valid && req_ready, !req_ready)

  // a failed allocation reports register zero
  `RRRA_ASSERT_NOW(a_fail_zero, clk, rst, rsp_valid && alloc_failed, chosen_reg == '0)

  // a stalled response beat holds
  `RRRA_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(chosen_reg) && $stable(alloc_failed))

endmodule

bind round_robin_reg_allocator_unit rrra_checker u_rrra_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .chosen_reg   (rsp.chosen_reg),
  .alloc_failed (rsp.alloc_failed)
);
